[rtl/core/rmsdt_pkg.sv]
`timescale 1ns / 1ps
package rmsdt_pkg;

  localparam int MAX_UNITS     = 16;
  localparam int WINDOW_LENGTH = 80;

  localparam int UNIT_W  = 4;
  localparam int CNT_W   = 16;
  localparam int CUR_W   = 24;
  localparam int MAG_W   = CUR_W + 1;
  localparam int SUM_W   = 54;
  localparam int Q_W     = 48;
  localparam int ROOT_W  = 24;
  localparam int SREM_W  = ROOT_W + 4;
  localparam int SLOT_W  = $clog2(WINDOW_LENGTH);
  localparam int ROWS    = MAX_UNITS * WINDOW_LENGTH;
  localparam int ADDR_W  = $clog2(ROWS);
  localparam int SUA_W   = $clog2(MAX_UNITS);
  localparam int AU_W    = 5;
  localparam int THR_W   = 24;
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  localparam logic [2:0] REG_ACTIVE_UNITS = 3'd0;
  localparam logic [2:0] REG_TRIP_THRESH  = 3'd1;
  localparam logic [2:0] REG_FIRST_UNIT   = 3'd2;
  localparam logic [2:0] REG_SECOND_UNIT  = 3'd3;
  localparam logic [2:0] REG_SYNC_UNIT    = 3'd4;

  typedef struct packed {
    logic [AU_W-1:0]   active_units;
    logic [THR_W-1:0]  trip_threshold;
    logic [UNIT_W-1:0] first_unit;
    logic [UNIT_W-1:0] second_unit;
    logic [UNIT_W-1:0] sync_unit;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rms_stat_t;

  function automatic logic [CUR_W-1:0] mag(input logic [CUR_W-1:0] x);
    mag = x[CUR_W-1] ? CUR_W'(~x + 1'b1) : x;
  endfunction

endpackage

[rtl/core/rmsdt_ram.sv]
`timescale 1ns / 1ps
module rmsdt_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/rmsdt_regs.sv]
`timescale 1ns / 1ps
module rmsdt_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rmsdt_pkg::PADDR_W-1:0]  paddr,
  input  logic [rmsdt_pkg::PDATA_W-1:0]  pwdata,
  output logic [rmsdt_pkg::PDATA_W-1:0]  prdata,
  output rmsdt_pkg::cfg_t                cfg
);
  import rmsdt_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic [2:0] idx;

  assign idx = paddr[PADDR_W-1:2];
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (psel && penable && pwrite) begin
      case (idx)
        REG_ACTIVE_UNITS: cfg_nxt.active_units   = pwdata[AU_W-1:0];
        REG_TRIP_THRESH:  cfg_nxt.trip_threshold = pwdata[THR_W-1:0];
        REG_FIRST_UNIT:   cfg_nxt.first_unit     = pwdata[UNIT_W-1:0];
        REG_SECOND_UNIT:  cfg_nxt.second_unit    = pwdata[UNIT_W-1:0];
        REG_SYNC_UNIT:    cfg_nxt.sync_unit      = pwdata[UNIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ACTIVE_UNITS: prdata = PDATA_W'(cfg_r.active_units);
      REG_TRIP_THRESH:  prdata = PDATA_W'(cfg_r.trip_threshold);
      REG_FIRST_UNIT:   prdata = PDATA_W'(cfg_r.first_unit);
      REG_SECOND_UNIT:  prdata = PDATA_W'(cfg_r.second_unit);
      REG_SYNC_UNIT:    prdata = PDATA_W'(cfg_r.sync_unit);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active_units   <= AU_W'(16);
      cfg_r.trip_threshold <= THR_W'(10000);
      cfg_r.first_unit     <= UNIT_W'(1);
      cfg_r.second_unit    <= UNIT_W'(7);
      cfg_r.sync_unit      <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[rtl/core/rmsdt_rms.sv]
`timescale 1ns / 1ps
module rmsdt_rms (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rmsdt_pkg::SUM_W-1:0] sum_i,
  output logic [rmsdt_pkg::ROOT_W-1:0] root,
  output rmsdt_pkg::rms_stat_t         stat
);
  import rmsdt_pkg::*;

  localparam logic [1:0] R_IDLE = 2'd0;
  localparam logic [1:0] R_DIV  = 2'd1;
  localparam logic [1:0] R_SQRT = 2'd2;

  logic [1:0]        st_r, st_nxt;
  logic [5:0]        cnt_r, cnt_nxt;
  logic [SUM_W-1:0]  dvd_r, dvd_nxt;
  logic [SUM_W-1:0]  q_r, q_nxt;
  logic [SLOT_W-1:0] drem_r, drem_nxt;
  logic [Q_W-1:0]    x_r, x_nxt;
  logic [SREM_W-1:0] srem_r, srem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic              done_r, done_nxt;
  logic [SLOT_W:0]   t;
  logic              ge;
  logic [SREM_W-1:0] r2, trial;

  assign root      = root_r;
  assign stat.busy = (st_r != R_IDLE);
  assign stat.done = done_r;

  always_comb begin
    st_nxt   = st_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    q_nxt    = q_r;
    drem_nxt = drem_r;
    x_nxt    = x_r;
    srem_nxt = srem_r;
    root_nxt = root_r;
    done_nxt = 1'b0;
    t        = {drem_r, dvd_r[SUM_W-1]};
    ge       = (t >= (SLOT_W+1)'(WINDOW_LENGTH));
    r2       = {srem_r[SREM_W-3:0], x_r[Q_W-1:Q_W-2]};
    trial    = SREM_W'({root_r, 2'b01});
    case (st_r)
      R_IDLE: begin
        if (start) begin
          dvd_nxt  = sum_i;
          drem_nxt = '0;
          q_nxt    = '0;
          cnt_nxt  = '0;
          st_nxt   = R_DIV;
        end
      end
      R_DIV: begin
        drem_nxt = ge ? SLOT_W'(t - (SLOT_W+1)'(WINDOW_LENGTH)) : t[SLOT_W-1:0];
        q_nxt    = {q_r[SUM_W-2:0], ge};
        dvd_nxt  = {dvd_r[SUM_W-2:0], 1'b0};
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == 6'(SUM_W-1)) begin
          x_nxt    = q_nxt[Q_W-1:0];
          srem_nxt = '0;
          root_nxt = '0;
          cnt_nxt  = '0;
          st_nxt   = R_SQRT;
        end
      end
      R_SQRT: begin
        if (r2 >= trial) begin
          srem_nxt = r2 - trial;
          root_nxt = {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          srem_nxt = r2;
          root_nxt = {root_r[ROOT_W-2:0], 1'b0};
        end
        x_nxt   = {x_r[Q_W-3:0], 2'b00};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 6'(ROOT_W-1)) begin
          done_nxt = 1'b1;
          st_nxt   = R_IDLE;
        end
      end
      default: st_nxt = R_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= R_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    dvd_r  <= dvd_nxt;
    q_r    <= q_nxt;
    drem_r <= drem_nxt;
    x_r    <= x_nxt;
    srem_r <= srem_nxt;
    root_r <= root_nxt;
  end

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !stat.busy) else $error("rms start while busy");
  a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !stat.busy) else $error("rms done while busy");
  a_done_after_sqrt: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(st_r) == R_SQRT) else $error("rms done without sqrt");

endmodule

[rtl/core/sv_rms_differential_trip_core.sv]
`timescale 1ns / 1ps
// RMS current differential trip core.
// Input channel (in_*): one sampled-values word per merging unit: unit index,
// sample counter and three phase currents. Output channel (out_*): exactly one
// result word per input word: accepted, evaluated, trip and the three held
// RMS differences. Both channels use valid/stall; an item is taken when valid
// is high and stall is low. Registers are written over the cfg_ APB port.
// One word is processed at a time. A rejected word goes straight to the
// result; a stored word runs the slot modulo, then the bit-serial
// square-sum update of each phase. While the sync unit's last stored word
// sat on slot 0 (also from reset on), each stored word computes six RMS
// values in turn on the shared serial divider and square root unit.
// After reset the sample window memory and the square sums are swept to zero,
// one row per cycle; in_stall is high during the sweep.
// A result waits in the output register while out_stall is high; the next
// word is taken meanwhile, and its result is held back until the register
// frees.
module sv_rms_differential_trip_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [3:0]                    in_unit_index,
  input  logic [15:0]                   in_sample_count,
  input  logic signed [23:0]            in_current_a,
  input  logic signed [23:0]            in_current_b,
  input  logic signed [23:0]            in_current_c,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_accepted,
  output logic                          out_evaluated,
  output logic                          out_trip,
  output logic [23:0]                   out_delta_a,
  output logic [23:0]                   out_delta_b,
  output logic [23:0]                   out_delta_c,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [rmsdt_pkg::PADDR_W-1:0] cfg_paddr,
  input  logic [rmsdt_pkg::PDATA_W-1:0] cfg_pwdata,
  output logic [rmsdt_pkg::PDATA_W-1:0] cfg_prdata,
  output logic                          cfg_pready
);
  import rmsdt_pkg::*;

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_MOD   = 4'd2;
  localparam logic [3:0] S_RDW   = 4'd3;
  localparam logic [3:0] S_PLD   = 4'd4;
  localparam logic [3:0] S_PMUL  = 4'd5;
  localparam logic [3:0] S_WB    = 4'd6;
  localparam logic [3:0] S_CHK   = 4'd7;
  localparam logic [3:0] S_EVRD  = 4'd8;
  localparam logic [3:0] S_EVW   = 4'd9;
  localparam logic [3:0] S_EVGO  = 4'd10;
  localparam logic [3:0] S_EVRUN = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  cfg_t      cfg;
  rms_stat_t rstat;
  logic [ROOT_W-1:0] rroot;

  logic [3:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic [UNIT_W-1:0] unit_r, unit_nxt;
  logic [CNT_W-1:0]  csh_r, csh_nxt;
  logic [CUR_W-1:0]  cur_r [3];
  logic [CUR_W-1:0]  cur_nxt [3];
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [4:0]        step_r, step_nxt;
  logic [ADDR_W-1:0] saddr_r, saddr_nxt;
  logic [SUA_W-1:0]  uaddr_r, uaddr_nxt;
  logic [1:0]        p_r, p_nxt;
  logic              k_r, k_nxt;
  logic [SUM_W-1:0]  acc_r, acc_nxt;
  logic [SUM_W-1:0]  dsh_r, dsh_nxt;
  logic [MAG_W-1:0]  ssh_r, ssh_nxt;
  logic [SUM_W-1:0]  nsum_r [3];
  logic [SUM_W-1:0]  nsum_nxt [3];
  logic [MAX_UNITS-1:0] zflag_r, zflag_nxt;
  logic              accf_r, accf_nxt;
  logic              evf_r, evf_nxt;
  logic              trip_r, trip_nxt;
  logic              any_r, any_nxt;
  logic [ROOT_W-1:0] r1_r, r1_nxt;
  logic              cmpok_r, cmpok_nxt;
  logic [CUR_W-1:0]  dlt_r [3];
  logic [CUR_W-1:0]  dlt_nxt [3];
  logic              out_valid_r;
  logic              out_acc_r, out_ev_r, out_trip_r;
  logic [CUR_W-1:0]  out_d_r [3];

  logic [3*CUR_W-1:0] samp_rdata, samp_wdata;
  logic [3*SUM_W-1:0] sums_rdata, sums_wdata;
  logic               samp_we, sums_we;
  logic [ADDR_W-1:0]  samp_waddr;
  logic [SUA_W-1:0]   sums_waddr;
  logic               rms_start;
  logic [SUM_W-1:0]   rms_sum;
  logic               in_acc, out_ld;
  logic [SLOT_W:0]    mt;
  logic [SLOT_W-1:0]  mrem;
  logic [CUR_W-1:0]   mn, mo;
  logic [MAG_W-1:0]   dd;
  logic [ROOT_W-1:0]  dv;

  rmsdt_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  rmsdt_ram #(.W(3*CUR_W), .D(ROWS)) u_samp_ram (
    .clk   (clk),
    .we    (samp_we),
    .waddr (samp_waddr),
    .wdata (samp_wdata),
    .raddr (saddr_r),
    .rdata (samp_rdata)
  );

  rmsdt_ram #(.W(3*SUM_W), .D(MAX_UNITS)) u_sums_ram (
    .clk   (clk),
    .we    (sums_we),
    .waddr (sums_waddr),
    .wdata (sums_wdata),
    .raddr (uaddr_r),
    .rdata (sums_rdata)
  );

  rmsdt_rms u_rms (
    .clk   (clk),
    .rst_n (rst_n),
    .start (rms_start),
    .sum_i (rms_sum),
    .root  (rroot),
    .stat  (rstat)
  );

  assign cfg_pready = 1'b1;
  assign in_stall   = (state_r != S_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign out_ld     = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  assign samp_we    = (state_r == S_CLR) || (state_r == S_WB);
  assign samp_waddr = (state_r == S_CLR) ? clr_r : saddr_r;
  assign samp_wdata = (state_r == S_CLR) ? '0 : {cur_r[2], cur_r[1], cur_r[0]};
  assign sums_we    = ((state_r == S_CLR) && (clr_r < ADDR_W'(MAX_UNITS)))
                      || (state_r == S_WB);
  assign sums_waddr = (state_r == S_CLR) ? SUA_W'(clr_r) : uaddr_r;
  assign sums_wdata = (state_r == S_CLR) ? '0 : {nsum_r[2], nsum_r[1], nsum_r[0]};

  assign rms_start  = (state_r == S_EVGO);
  assign rms_sum    = cmpok_r ? sums_rdata[p_r*SUM_W +: SUM_W] : '0;

  assign mt   = {slot_r, csh_r[CNT_W-1]};
  assign mrem = (mt >= (SLOT_W+1)'(WINDOW_LENGTH))
                ? SLOT_W'(mt - (SLOT_W+1)'(WINDOW_LENGTH)) : mt[SLOT_W-1:0];
  assign mn   = mag(cur_r[p_r]);
  assign mo   = mag(samp_rdata[p_r*CUR_W +: CUR_W]);
  assign dd   = MAG_W'(mn) - MAG_W'(mo);
  assign dv   = (r1_r >= rroot) ? (r1_r - rroot) : (rroot - r1_r);

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    unit_nxt  = unit_r;
    csh_nxt   = csh_r;
    cur_nxt   = cur_r;
    slot_nxt  = slot_r;
    step_nxt  = step_r;
    saddr_nxt = saddr_r;
    uaddr_nxt = uaddr_r;
    p_nxt     = p_r;
    k_nxt     = k_r;
    acc_nxt   = acc_r;
    dsh_nxt   = dsh_r;
    ssh_nxt   = ssh_r;
    nsum_nxt  = nsum_r;
    zflag_nxt = zflag_r;
    accf_nxt  = accf_r;
    evf_nxt   = evf_r;
    trip_nxt  = trip_r;
    any_nxt   = any_r;
    r1_nxt    = r1_r;
    cmpok_nxt = cmpok_r;
    dlt_nxt   = dlt_r;
    case (state_r)
      S_CLR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == ADDR_W'(ROWS-1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          unit_nxt   = in_unit_index;
          csh_nxt    = in_sample_count;
          cur_nxt[0] = in_current_a;
          cur_nxt[1] = in_current_b;
          cur_nxt[2] = in_current_c;
          slot_nxt   = '0;
          step_nxt   = '0;
          evf_nxt    = 1'b0;
          accf_nxt   = (in_unit_index < cfg.active_units)
                       && (32'(in_unit_index) < MAX_UNITS);
          state_nxt  = accf_nxt ? S_MOD : S_DONE;
        end
      end
      S_MOD: begin
        slot_nxt = mrem;
        csh_nxt  = {csh_r[CNT_W-2:0], 1'b0};
        step_nxt = step_r + 1'b1;
        if (step_r == 5'(CNT_W-1)) begin
          saddr_nxt = ADDR_W'(unit_r) * ADDR_W'(WINDOW_LENGTH) + ADDR_W'(mrem);
          uaddr_nxt = SUA_W'(unit_r);
          p_nxt     = '0;
          state_nxt = S_RDW;
        end
      end
      S_RDW: state_nxt = S_PLD;
      S_PLD: begin
        acc_nxt   = sums_rdata[p_r*SUM_W +: SUM_W];
        dsh_nxt   = {{(SUM_W-MAG_W){dd[MAG_W-1]}}, dd};
        ssh_nxt   = MAG_W'(mn) + MAG_W'(mo);
        step_nxt  = '0;
        state_nxt = S_PMUL;
      end
      S_PMUL: begin
        if (ssh_r[0]) begin
          acc_nxt = acc_r + dsh_r;
        end
        dsh_nxt  = {dsh_r[SUM_W-2:0], 1'b0};
        ssh_nxt  = {1'b0, ssh_r[MAG_W-1:1]};
        step_nxt = step_r + 1'b1;
        if (step_r == 5'(MAG_W-1)) begin
          nsum_nxt[p_r] = acc_nxt;
          p_nxt         = p_r + 1'b1;
          state_nxt     = (p_r == 2'd2) ? S_WB : S_PLD;
        end
      end
      S_WB: begin
        zflag_nxt[SUA_W'(unit_r)] = (slot_r == '0);
        state_nxt = S_CHK;
      end
      S_CHK: begin
        p_nxt   = '0;
        k_nxt   = 1'b0;
        any_nxt = 1'b0;
        if ((32'(cfg.sync_unit) < MAX_UNITS) && zflag_r[SUA_W'(cfg.sync_unit)]) begin
          evf_nxt   = 1'b1;
          state_nxt = S_EVRD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_EVRD: begin
        if (k_r) begin
          uaddr_nxt = SUA_W'(cfg.second_unit);
          cmpok_nxt = (32'(cfg.second_unit) < MAX_UNITS);
        end else begin
          uaddr_nxt = SUA_W'(cfg.first_unit);
          cmpok_nxt = (32'(cfg.first_unit) < MAX_UNITS);
        end
        state_nxt = S_EVW;
      end
      S_EVW:  state_nxt = S_EVGO;
      S_EVGO: state_nxt = S_EVRUN;
      S_EVRUN: begin
        if (rstat.done) begin
          if (!k_r) begin
            r1_nxt    = rroot;
            k_nxt     = 1'b1;
            state_nxt = S_EVRD;
          end else begin
            dlt_nxt[p_r] = dv;
            any_nxt      = any_r || (dv > cfg.trip_threshold);
            k_nxt        = 1'b0;
            p_nxt        = p_r + 1'b1;
            if (p_r == 2'd2) begin
              trip_nxt  = any_nxt;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_EVRD;
            end
          end
        end
      end
      S_DONE: begin
        if (out_ld) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      zflag_r     <= '1;
      trip_r      <= 1'b0;
      dlt_r[0]    <= '0;
      dlt_r[1]    <= '0;
      dlt_r[2]    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      zflag_r <= zflag_nxt;
      trip_r  <= trip_nxt;
      dlt_r   <= dlt_nxt;
      if (out_ld) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    unit_r  <= unit_nxt;
    csh_r   <= csh_nxt;
    cur_r   <= cur_nxt;
    slot_r  <= slot_nxt;
    step_r  <= step_nxt;
    saddr_r <= saddr_nxt;
    uaddr_r <= uaddr_nxt;
    p_r     <= p_nxt;
    k_r     <= k_nxt;
    acc_r   <= acc_nxt;
    dsh_r   <= dsh_nxt;
    ssh_r   <= ssh_nxt;
    nsum_r  <= nsum_nxt;
    accf_r  <= accf_nxt;
    evf_r   <= evf_nxt;
    any_r   <= any_nxt;
    r1_r    <= r1_nxt;
    cmpok_r <= cmpok_nxt;
    if (out_ld) begin
      out_acc_r  <= accf_r;
      out_ev_r   <= evf_r;
      out_trip_r <= trip_r;
      out_d_r    <= dlt_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_accepted  = out_acc_r;
  assign out_evaluated = out_ev_r;
  assign out_trip      = out_trip_r;
  assign out_delta_a   = out_d_r[0];
  assign out_delta_b   = out_d_r[1];
  assign out_delta_c   = out_d_r[2];

  a_eval_stored: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ev_r |-> out_acc_r) else $error("evaluated word not stored");
  a_no_out_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> !out_valid_r) else $error("result during clear sweep");
  a_rows_paired: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_CLR) |-> (samp_we == sums_we)) else $error("unpaired row write");
  a_rms_only_eval: assert property (@(posedge clk) disable iff (!rst_n)
    rstat.done |-> (state_r == S_EVRUN)) else $error("rms result outside evaluation");

endmodule
